/* rtl/core/crs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types and constants for the checksummed record store.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 256;
  localparam int unsigned ADDR_W          = 8;
  localparam int unsigned VALUE_W         = 16;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned TRIPLE_LEN      = 3;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_WR,
    ST_RD,
    ST_CHK,
    ST_OUT
  } crs_state_e;

endpackage

/* rtl/core/checksummed_record_store_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_record_store_top
// Byte store holding 16-bit records as low/high/sum triples, with a backup
// triple right after the primary one and an 8-bit additive checksum.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, req_type_i,      | beat in
//          | base_addr_i, write_value_i               |
//  out     | out_valid_o, out_stall_i, ok_o,          | beat out
//          | read_value_o                             |
//
//  One request at a time: the base is reduced modulo the store depth by
//  repeated subtraction, a write stores the low, high and sum bytes of its
//  triple, a read fetches and checks the primary triple and, if that fails,
//  the backup, then the output register is loaded and idle takes the next
//  beat. Reset clears the per-byte valid bits at once. The sequencer holds
//  only while the output register is full.
// ----------------------------------------------------------------------------
module checksummed_record_store_top
  import crs_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [ADDR_W-1:0]    base_addr_i,
  input  logic [VALUE_W-1:0]   write_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 ok_o,
  output logic [VALUE_W-1:0]   read_value_o
);

  localparam int unsigned PW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [ADDR_W:0] DEPTH_W = (ADDR_W + 1)'(STORE_DEPTH);
  localparam logic [PW-1:0]   PTR_LAST = PW'(STORE_DEPTH - 1);
  localparam logic [1:0]      CNT_LAST = 2'(TRIPLE_LEN);
  localparam logic [1:0]      CNT_WR_LAST = 2'(TRIPLE_LEN - 1);

  crs_state_e state_q, state_d;

  logic [BYTE_W-1:0]  mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_q;
  logic [BYTE_W-1:0]  rdata_q;
  logic               rvld_q;

  logic               req_q;
  logic [ADDR_W-1:0]  rem_q;
  logic [VALUE_W-1:0] wval_q;
  logic [PW-1:0]      ptr_q;
  logic [1:0]         cnt_q;
  logic               bk_q;
  logic [BYTE_W-1:0]  b0_q, b1_q, b2_q;
  logic               ok_q;
  logic [VALUE_W-1:0] last_good_q;
  logic               out_valid_q;
  logic               out_ok_q;
  logic [VALUE_W-1:0] out_val_q;

  logic               accept;
  logic               rem_big;
  logic               out_free;
  logic [BYTE_W-1:0]  add_a, add_b, add_s;
  logic               good;
  logic [BYTE_W-1:0]  rbyte;
  logic [BYTE_W-1:0]  wdata;
  logic [PW-1:0]      ptr_nxt;

  logic mem_we, mem_re, cap, ptr_ld, ptr_inc, rem_sub, cnt_clr, cnt_inc;
  logic chk_ld, bk_set, out_ld, wr_done;

  assign accept   = in_valid_i && !in_stall_o;
  assign rem_big  = {1'b0, rem_q} >= DEPTH_W;
  assign out_free = !out_valid_q || !out_stall_i;
  assign ptr_nxt  = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
  assign rbyte    = rvld_q ? rdata_q : '0;

  // shared 8-bit adder: checksum on write, checksum check on read
  assign add_a = (state_q == ST_WR) ? wval_q[BYTE_W-1:0] : b0_q;
  assign add_b = (state_q == ST_WR) ? wval_q[VALUE_W-1:BYTE_W] : b1_q;
  assign add_s = add_a + add_b;
  assign good  = (add_s == b2_q);

  always_comb begin
    unique case (cnt_q)
      2'd0:    wdata = wval_q[BYTE_W-1:0];
      2'd1:    wdata = wval_q[VALUE_W-1:BYTE_W];
      default: wdata = add_s;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_MOD;
      end
      ST_MOD: begin
        if (!rem_big) state_d = (req_q == REQ_WRITE) ? ST_WR : ST_RD;
      end
      ST_WR: begin
        if (cnt_q == CNT_WR_LAST) state_d = ST_OUT;
      end
      ST_RD: begin
        if (cnt_q == CNT_LAST) state_d = ST_CHK;
      end
      ST_CHK: begin
        state_d = (good || bk_q) ? ST_OUT : ST_RD;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    cap     = 1'b0;
    ptr_ld  = 1'b0;
    ptr_inc = 1'b0;
    rem_sub = 1'b0;
    cnt_clr = 1'b0;
    cnt_inc = 1'b0;
    chk_ld  = 1'b0;
    bk_set  = 1'b0;
    out_ld  = 1'b0;
    wr_done = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_MOD: begin
        rem_sub = rem_big;
        ptr_ld  = !rem_big;
        cnt_clr = !rem_big;
      end
      ST_WR: begin
        mem_we  = 1'b1;
        ptr_inc = 1'b1;
        cnt_inc = 1'b1;
        wr_done = (cnt_q == CNT_WR_LAST);
      end
      ST_RD: begin
        mem_re  = (cnt_q != CNT_LAST);
        ptr_inc = (cnt_q != CNT_LAST);
        cap     = (cnt_q != 2'd0);
        cnt_inc = 1'b1;
      end
      ST_CHK: begin
        chk_ld  = 1'b1;
        bk_set  = !good && !bk_q;
        cnt_clr = 1'b1;
      end
      ST_OUT: begin
        out_ld = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[ptr_q] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (mem_we) vld_q[ptr_q] <= 1'b1;
      if (mem_re) rvld_q <= vld_q[ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_type_i;
      rem_q  <= base_addr_i;
      wval_q <= write_value_i;
    end else if (rem_sub) begin
      rem_q <= ADDR_W'({1'b0, rem_q} - DEPTH_W);
    end
    if (ptr_ld) begin
      ptr_q <= rem_q[PW-1:0];
    end else if (ptr_inc) begin
      ptr_q <= ptr_nxt;
    end
    // shift in: once a triple's three bytes are in, b0 = low, b1 = high, b2 = sum
    if (cap) begin
      b0_q <= b1_q;
      b1_q <= b2_q;
      b2_q <= rbyte;
    end
    if (out_ld) begin
      out_ok_q  <= ok_q;
      out_val_q <= last_good_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      bk_q        <= 1'b0;
      ok_q        <= 1'b0;
      last_good_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cnt_clr) begin
        cnt_q <= '0;
      end else if (cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (accept) begin
        bk_q <= 1'b0;
      end else if (bk_set) begin
        bk_q <= 1'b1;
      end
      if (wr_done) begin
        ok_q <= 1'b1;
      end else if (chk_ld) begin
        ok_q <= good;
        if (good) last_good_q <= {b1_q, b0_q};
      end
      out_valid_q <= out_ld || (out_valid_q && out_stall_i);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = out_ok_q;
  assign read_value_o = out_val_q;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the checksummed record store. A scoreboard keeps
// its own copy of the byte store and the last good value, predicts ok and
// read_value for every accepted request beat and checks each result beat in
// order. Directed requests cover the fresh store, address wrap, backup
// fallback and both copies bad; random record sequences with damage follow,
// under random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import crs_pkg::*;

  localparam int unsigned ITEM_TARGET    = 1950;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 24;
  localparam int unsigned HOLD_OFF_BEATS = 300;
  localparam int unsigned HOLD_OFF_LEN   = 150;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] value;
  } record_result_t;

  class record_scoreboard;
    logic [BYTE_W-1:0]  store_bytes [STORE_DEPTH_DEF];
    logic [VALUE_W-1:0] last_good;
    record_result_t     expected_results [$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        n_writes;
    int unsigned        n_primary;
    int unsigned        n_backup;
    int unsigned        n_both_bad;

    function new();
      foreach (store_bytes[i]) store_bytes[i] = '0;
      last_good  = '0;
      mismatches = 0;
      checked    = 0;
      n_writes   = 0;
      n_primary  = 0;
      n_backup   = 0;
      n_both_bad = 0;
    endfunction

    function bit read_triple(input logic [ADDR_W-1:0] base,
                             output logic [VALUE_W-1:0] value);
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] hi;
      logic [BYTE_W-1:0] sum;
      lo    = store_bytes[base];
      hi    = store_bytes[ADDR_W'(base + 1)];
      sum   = store_bytes[ADDR_W'(base + 2)];
      value = {hi, lo};
      return BYTE_W'(lo + hi) == sum;
    endfunction

    function void note_request(logic rq, logic [ADDR_W-1:0] base,
                               logic [VALUE_W-1:0] wv);
      record_result_t     res;
      logic [VALUE_W-1:0] v;
      if (rq == REQ_WRITE) begin
        store_bytes[base]               = wv[7:0];
        store_bytes[ADDR_W'(base + 1)]  = wv[15:8];
        store_bytes[ADDR_W'(base + 2)]  = BYTE_W'(wv[7:0] + wv[15:8]);
        res.ok = 1'b1;
        n_writes++;
      end else if (read_triple(base, v)) begin
        last_good = v;
        res.ok    = 1'b1;
        n_primary++;
      end else if (read_triple(ADDR_W'(base + TRIPLE_LEN), v)) begin
        last_good = v;
        res.ok    = 1'b1;
        n_backup++;
      end else begin
        res.ok = 1'b0;
        n_both_bad++;
      end
      res.value = last_good;
      expected_results.push_back(res);
    endfunction

    function void check_result(logic ok, logic [VALUE_W-1:0] value);
      record_result_t exp;
      checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] result beat with nothing pending: ok=%0b value=%h",
                   $time, ok, value);
        return;
      end
      exp = expected_results.pop_front();
      if (exp.ok !== ok || exp.value !== value) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] result %0d: expected ok=%0b value=%h, got ok=%0b value=%h",
                   $time, checked, exp.ok, exp.value, ok, value);
      end
    endfunction
  endclass

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               req_type    = REQ_READ;
  logic [ADDR_W-1:0]  base_addr   = '0;
  logic [VALUE_W-1:0] write_value = '0;
  logic               out_stall   = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic               ok_o;
  logic [VALUE_W-1:0] read_value_o;

  record_scoreboard   scoreboard;
  int unsigned        items_sent    = 0;
  bit                 steady_sender = 1'b0;
  logic [ADDR_W-1:0]  window_base   = '0;

  checksummed_record_store_top dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type),
    .base_addr_i  (base_addr),
    .write_value_i(write_value),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .ok_o         (ok_o),
    .read_value_o (read_value_o)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_request(input logic rq, input logic [ADDR_W-1:0] ba,
                              input logic [VALUE_W-1:0] wv);
    int unsigned gap;
    gap = steady_sender ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= rq;
    base_addr   <= ba;
    write_value <= wv;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    scoreboard.note_request(rq, ba, wv);
    items_sent++;
    if (items_sent % 64 == 0) steady_sender = ($urandom_range(0, 3) == 0);
  endtask

  function automatic logic [ADDR_W-1:0] pick_base();
    if ($urandom_range(0, 99) < 60) return ADDR_W'(window_base + $urandom_range(0, 11));
    return ADDR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h00FF;
      3:       return 16'hFF00;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic send_directed();
    send_request(REQ_READ,  8'd0,   16'hFFFF);
    send_request(REQ_READ,  8'd255, 16'h0000);
    send_request(REQ_WRITE, 8'd0,   16'h1234);
    send_request(REQ_READ,  8'd0,   16'h0000);
    send_request(REQ_WRITE, 8'd10,  16'hFFFF);
    send_request(REQ_READ,  8'd10,  16'h0000);
    send_request(REQ_WRITE, 8'd254, 16'hA55A);
    send_request(REQ_READ,  8'd254, 16'h0000);
    send_request(REQ_WRITE, 8'd255, 16'h0000);
    send_request(REQ_READ,  8'd255, 16'hFFFF);
    // damage primary at 40, keep backup at 43
    send_request(REQ_WRITE, 8'd43,  16'h5A3C);
    send_request(REQ_WRITE, 8'd40,  16'h0000);
    send_request(REQ_WRITE, 8'd38,  16'h0101);
    send_request(REQ_READ,  8'd40,  16'h0000);
    // damage both copies at 80
    send_request(REQ_WRITE, 8'd78,  16'h0101);
    send_request(REQ_WRITE, 8'd81,  16'h0101);
    send_request(REQ_READ,  8'd80,  16'h0000);
    // backup wraps past the top of the store
    send_request(REQ_WRITE, 8'd0,   16'h2211);
    send_request(REQ_WRITE, 8'd251, 16'h0101);
    send_request(REQ_READ,  8'd253, 16'h0000);
    send_request(REQ_WRITE, 8'd128, 16'hFFFF);
    send_request(REQ_READ,  8'd128, 16'h0000);
    send_request(REQ_WRITE, 8'd200, 16'h8001);
    send_request(REQ_READ,  8'd200, 16'hFFFF);
  endtask

  task automatic send_random();
    int unsigned        pick;
    logic [ADDR_W-1:0]  b;
    logic [VALUE_W-1:0] v;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 31) == 0) window_base = ADDR_W'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      b    = pick_base();
      v    = pick_value();
      if (pick < 45) begin
        // record, usually with its backup copy, sometimes damaged, then read back
        send_request(REQ_WRITE, b, v);
        if ($urandom_range(0, 3) != 0)
          send_request(REQ_WRITE, ADDR_W'(b + TRIPLE_LEN),
                       ($urandom_range(0, 3) == 0) ? pick_value() : v);
        if ($urandom_range(0, 1) != 0)
          send_request(REQ_WRITE, ADDR_W'(b + $urandom_range(0, 7) - 2), pick_value());
        send_request(REQ_READ, b, VALUE_W'($urandom));
      end else if (pick < 70) begin
        send_request(REQ_WRITE, b, v);
      end else begin
        send_request(REQ_READ, b, v);
      end
    end
  endtask

  initial begin
    int unsigned gap;
    int unsigned accepted;
    bit          hold_done;
    bit          steady_receiver;
    accepted        = 0;
    hold_done       = 1'b0;
    steady_receiver = 1'b0;
    forever begin
      if (!hold_done && accepted >= HOLD_OFF_BEATS) begin
        gap       = HOLD_OFF_LEN;
        hold_done = 1'b1;
      end else begin
        gap = steady_receiver ? 0 : $urandom_range(0, 6);
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid_o) @(posedge clk);
      scoreboard.check_result(ok_o, read_value_o);
      accepted++;
      if (accepted % 64 == 0) steady_receiver = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[%0t] watchdog: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    int unsigned errors;
    scoreboard = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed();
    send_random();
    in_valid <= 1'b0;
    while (scoreboard.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    errors = scoreboard.mismatches + scoreboard.expected_results.size();
    $display("tb_top: %0d requests: %0d writes, reads good on primary %0d, on backup %0d, both bad %0d",
             items_sent, scoreboard.n_writes, scoreboard.n_primary,
             scoreboard.n_backup, scoreboard.n_both_bad);
    $display("tb_top: %0d results checked, %0d mismatches, %0d left pending",
             scoreboard.checked, scoreboard.mismatches,
             scoreboard.expected_results.size());
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/crs_pkg.sv
rtl/core/checksummed_record_store_top.sv
tb/tb_top.sv
